[hw/rtl/kwm_pkg.sv]
// shared types and constants for the k-way sorted merge
package kwm_pkg;

  localparam int LIST_BITS  = 3;
  localparam int LIST_SPACE = 8;
  localparam int CFG_BITS   = 4;
  localparam int MASK_BITS  = 16;
  localparam int OUT_BITS   = 32;
  localparam int IN_BITS    = 32;

  localparam logic [CFG_BITS-1:0] CFG_RESET = 4'd8;

  typedef struct packed {
    logic ins;
    logic pop;
  } kwm_op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } kwm_state_t;

  typedef enum logic [2:0] {
    PH_PRIME = 3'b001,
    PH_MERGE = 3'b010,
    PH_DONE  = 3'b100
  } kwm_phase_t;

endpackage

[hw/rtl/kwm_cell.sv]
// one cell of the sorted head chain
module kwm_cell #(
  parameter int VALUE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  kwm_pkg::kwm_op_t               op,
  input  logic [VALUE_BITS-1:0]          new_value,
  input  logic [kwm_pkg::LIST_BITS-1:0]  new_list,
  input  logic                           left_ins,
  input  logic                           left_valid,
  input  logic [VALUE_BITS-1:0]          left_value,
  input  logic [kwm_pkg::LIST_BITS-1:0]  left_list,
  input  logic                           right_valid,
  input  logic [VALUE_BITS-1:0]          right_value,
  input  logic [kwm_pkg::LIST_BITS-1:0]  right_list,
  output logic                           valid,
  output logic [VALUE_BITS-1:0]          value,
  output logic [kwm_pkg::LIST_BITS-1:0]  list,
  output logic                           ins
);

  // new entry goes ahead of this one
  assign ins = !valid
             || ($signed(new_value) < $signed(value))
             || ((new_value == value) && (new_list < list));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (op.pop) begin
      valid <= right_valid;
    end else if (op.ins && ins) begin
      valid <= left_ins ? left_valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (op.pop) begin
      value <= right_value;
      list  <= right_list;
    end else if (op.ins && ins) begin
      if (left_ins) begin
        value <= left_value;
        list  <= left_list;
      end else begin
        value <= new_value;
        list  <= new_list;
      end
    end
  end

endmodule

[hw/rtl/kwm_chain.sv]
// row of cells holding pending heads in ascending order
module kwm_chain #(
  parameter int MAX_LISTS  = 8,
  parameter int VALUE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  kwm_pkg::kwm_op_t               op,
  input  logic [VALUE_BITS-1:0]          new_value,
  input  logic [kwm_pkg::LIST_BITS-1:0]  new_list,
  output logic                           head_valid,
  output logic [VALUE_BITS-1:0]          head_value,
  output logic [kwm_pkg::LIST_BITS-1:0]  head_list
);

  logic                          c_valid [MAX_LISTS+1];
  logic [VALUE_BITS-1:0]         c_value [MAX_LISTS+1];
  logic [kwm_pkg::LIST_BITS-1:0] c_list  [MAX_LISTS+1];
  logic                          c_ins   [MAX_LISTS];

  // empty slot past the last cell
  assign c_valid[MAX_LISTS] = 1'b0;
  assign c_value[MAX_LISTS] = '0;
  assign c_list[MAX_LISTS]  = '0;

  for (genvar i = 0; i < MAX_LISTS; i++) begin : g_cell
    logic                          l_ins;
    logic                          l_valid;
    logic [VALUE_BITS-1:0]         l_value;
    logic [kwm_pkg::LIST_BITS-1:0] l_list;

    if (i == 0) begin : g_first
      assign l_ins   = 1'b0;
      assign l_valid = 1'b0;
      assign l_value = '0;
      assign l_list  = '0;
    end else begin : g_rest
      assign l_ins   = c_ins[i-1];
      assign l_valid = c_valid[i-1];
      assign l_value = c_value[i-1];
      assign l_list  = c_list[i-1];
    end

    kwm_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (op),
      .new_value   (new_value),
      .new_list    (new_list),
      .left_ins    (l_ins),
      .left_valid  (l_valid),
      .left_value  (l_value),
      .left_list   (l_list),
      .right_valid (c_valid[i+1]),
      .right_value (c_value[i+1]),
      .right_list  (c_list[i+1]),
      .valid       (c_valid[i]),
      .value       (c_value[i]),
      .list        (c_list[i]),
      .ins         (c_ins[i])
    );
  end

  assign head_valid = c_valid[0];
  assign head_value = c_value[0];
  assign head_list  = c_list[0];

endmodule

[hw/rtl/k_way_sorted_merge_top.sv]
// top level of the k-way sorted merge
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_ready     req_type, list_id, elem_value
//   out      output     out_valid / out_ready   out_value, source_list, all_done, order_error
//   cfg      input      cfg_wr_en               cfg_wr_data (active_lists)
//
// an item that gives a result is accepted in ST_IDLE, where a valid element request inserts its head
// into the cell chain; ST_EMIT then pops the chain head into the output register.
// a priming item with no result leaves the block in ST_IDLE.
// a full output register holds the emit cycle until out_ready.
// rst is synchronous and clears the chain, phase, primed lists and active_lists to 8.
module k_way_sorted_merge_top #(
  parameter int MAX_LISTS  = 8,
  parameter int VALUE_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [kwm_pkg::CFG_BITS-1:0]       cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               req_type,
  input  logic [kwm_pkg::LIST_BITS-1:0]      list_id,
  input  logic signed [kwm_pkg::IN_BITS-1:0] elem_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [kwm_pkg::OUT_BITS-1:0] out_value,
  output logic [kwm_pkg::LIST_BITS-1:0]      source_list,
  output logic                               all_done,
  output logic                               order_error
);

  kwm_pkg::kwm_state_t               state;
  kwm_pkg::kwm_phase_t               phase;
  logic [kwm_pkg::CFG_BITS-1:0]      active_lists;
  logic [kwm_pkg::LIST_SPACE-1:0]    primed;
  logic [kwm_pkg::LIST_BITS-1:0]     awaited;
  logic                              pend_err;
  logic [kwm_pkg::LIST_BITS-1:0]     pend_list;

  logic [kwm_pkg::CFG_BITS-1:0]      eff;
  logic [kwm_pkg::MASK_BITS-1:0]     act_mask;
  logic [kwm_pkg::LIST_SPACE-1:0]    bit_sel;
  logic [kwm_pkg::LIST_SPACE-1:0]    primed_next;
  logic                              accept;
  logic                              bad;
  logic                              need_pop;
  logic                              out_free;
  logic                              emit;
  logic [63:0]                       in_ext;
  logic [63:0]                       head_ext;

  kwm_pkg::kwm_op_t                  op;
  logic                              head_valid;
  logic [VALUE_BITS-1:0]             head_value;
  logic [kwm_pkg::LIST_BITS-1:0]     head_list;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == kwm_pkg::ST_IDLE);
  assign out_free = !out_valid || out_ready;
  assign emit     = (state == kwm_pkg::ST_EMIT) && out_free;

  always_comb begin
    if (active_lists == '0) begin
      eff = kwm_pkg::CFG_BITS'(1);
    end else if (int'(active_lists) > MAX_LISTS) begin
      eff = kwm_pkg::CFG_BITS'(MAX_LISTS);
    end else begin
      eff = active_lists;
    end
  end

  assign act_mask    = (kwm_pkg::MASK_BITS'(1) << eff) - kwm_pkg::MASK_BITS'(1);
  assign bit_sel     = kwm_pkg::LIST_SPACE'(1) << list_id;
  assign primed_next = primed | bit_sel;

  always_comb begin
    bad      = 1'b1;
    need_pop = 1'b0;
    case (phase)
      kwm_pkg::PH_PRIME: begin
        bad      = ({1'b0, list_id} >= eff) || ((primed & bit_sel) != '0);
        need_pop = ((kwm_pkg::MASK_BITS'(primed_next) & act_mask) == act_mask);
      end
      kwm_pkg::PH_MERGE: begin
        bad      = (list_id != awaited);
        need_pop = 1'b1;
      end
      default: begin
        bad      = 1'b1;
        need_pop = 1'b0;
      end
    endcase
  end

  assign in_ext   = 64'(elem_value);
  assign head_ext = 64'(head_value);

  assign op.ins = accept && !bad && !req_type;
  assign op.pop = emit && !pend_err && head_valid;

  kwm_chain #(
    .MAX_LISTS  (MAX_LISTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_chain (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .new_value  (in_ext[VALUE_BITS-1:0]),
    .new_list   (list_id),
    .head_valid (head_valid),
    .head_value (head_value),
    .head_list  (head_list)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      active_lists <= kwm_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      active_lists <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= kwm_pkg::ST_IDLE;
      phase   <= kwm_pkg::PH_PRIME;
      primed  <= '0;
      awaited <= '0;
    end else begin
      case (state)
        kwm_pkg::ST_IDLE: begin
          if (accept) begin
            if (!bad && (phase == kwm_pkg::PH_PRIME)) begin
              primed <= primed_next;
            end
            if (bad || need_pop) begin
              state <= kwm_pkg::ST_EMIT;
            end
          end
        end
        kwm_pkg::ST_EMIT: begin
          if (out_free) begin
            state <= kwm_pkg::ST_IDLE;
            if (!pend_err) begin
              if (head_valid) begin
                phase   <= kwm_pkg::PH_MERGE;
                awaited <= head_list;
              end else begin
                phase <= kwm_pkg::PH_DONE;
              end
            end
          end
        end
        default: begin
          state <= kwm_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_err  <= bad;
      pend_list <= list_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (pend_err) begin
        out_value   <= '0;
        source_list <= pend_list;
        all_done    <= (phase == kwm_pkg::PH_DONE);
        order_error <= 1'b1;
      end else if (head_valid) begin
        out_value   <= head_ext[kwm_pkg::OUT_BITS-1:0];
        source_list <= head_list;
        all_done    <= 1'b0;
        order_error <= 1'b0;
      end else begin
        out_value   <= '0;
        source_list <= '0;
        all_done    <= 1'b1;
        order_error <= 1'b0;
      end
    end
  end

  a_emit_leaves: assert property (@(posedge clk) disable iff (rst)
    (state == kwm_pkg::ST_EMIT) && out_free |=> (state == kwm_pkg::ST_IDLE))
    else $error("emit state held with a free output register");

  a_done_empty: assert property (@(posedge clk) disable iff (rst)
    (phase == kwm_pkg::PH_DONE) |-> !head_valid)
    else $error("pending heads left after done");

  a_done_result: assert property (@(posedge clk) disable iff (rst)
    (phase == kwm_pkg::PH_DONE) && ($past(phase) != kwm_pkg::PH_DONE)
    |-> out_valid && all_done && !order_error)
    else $error("done phase entered without a done item");

endmodule

[verif/tb_k_way_sorted_merge_top.sv]
// testbench for k_way_sorted_merge_top: one checked merge session with noise and config changes
`timescale 1ns / 1ps

typedef struct packed {
  logic signed [kwm_pkg::OUT_BITS-1:0] value;
  logic [kwm_pkg::LIST_BITS-1:0]       src;
  logic                                done;
  logic                                err;
} merge_result_t;

class merge_scoreboard;
  logic signed [31:0] head_val [8];
  logic [2:0]         head_list [8];
  int                 head_count;
  logic [7:0]         primed;
  logic [2:0]         awaited;
  kwm_pkg::kwm_phase_t phase;
  logic [3:0]         active;
  merge_result_t      pending_results [$];
  int                 failures;

  function new();
    head_count = 0;
    primed = '0;
    awaited = '0;
    phase = kwm_pkg::PH_PRIME;
    active = kwm_pkg::CFG_RESET;
    failures = 0;
  endfunction

  function void set_active(logic [3:0] v);
    active = v;
  endfunction

  function int eff_lists();
    if (active == 4'd0) return 1;
    if (active > 4'd8) return 8;
    return int'(active);
  endfunction

  function void push_result(logic signed [31:0] v, logic [2:0] s, logic d, logic e);
    merge_result_t r;
    r.value = v;
    r.src = s;
    r.done = d;
    r.err = e;
    pending_results = {pending_results, r};
  endfunction

  function void add_head(logic signed [31:0] v, logic [2:0] lid);
    if (head_count < 8) begin
      head_val[head_count] = v;
      head_list[head_count] = lid;
      head_count++;
    end
  endfunction

  function void pop_smallest();
    int best;
    best = 0;
    if (head_count == 0) begin
      phase = kwm_pkg::PH_DONE;
      push_result('0, '0, 1'b1, 1'b0);
      return;
    end
    for (int i = 1; i < head_count; i++) begin
      if (head_val[i] < head_val[best] ||
          (head_val[i] == head_val[best] && head_list[i] < head_list[best]))
        best = i;
    end
    push_result(head_val[best], head_list[best], 1'b0, 1'b0);
    awaited = head_list[best];
    phase = kwm_pkg::PH_MERGE;
    head_count--;
    head_val[best] = head_val[head_count];
    head_list[best] = head_list[head_count];
  endfunction

  function void note_input(logic rt, logic [2:0] lid, logic signed [31:0] val);
    logic [7:0] amask;
    logic [7:0] bitpos;
    amask = 8'((9'd1 << eff_lists()) - 9'd1);
    bitpos = 8'd1 << lid;
    case (phase)
      kwm_pkg::PH_PRIME: begin
        if (int'(lid) >= eff_lists() || (primed & bitpos) != 8'd0) begin
          push_result('0, lid, 1'b0, 1'b1);
        end else begin
          primed = primed | bitpos;
          if (!rt) add_head(val, lid);
          if ((primed & amask) == amask) pop_smallest();
        end
      end
      kwm_pkg::PH_MERGE: begin
        if (lid != awaited) begin
          push_result('0, lid, 1'b0, 1'b1);
        end else begin
          if (!rt) add_head(val, lid);
          pop_smallest();
        end
      end
      default: push_result('0, lid, 1'b1, 1'b1);
    endcase
  endfunction

  function void check(logic signed [31:0] v, logic [2:0] s, logic d, logic e);
    merge_result_t r;
    if (pending_results.size() == 0) begin
      $error("unexpected result: out_value %0d source_list %0d all_done %0b order_error %0b",
             v, s, d, e);
      failures++;
      return;
    end
    r = pending_results.pop_front();
    if (v !== r.value) begin
      $error("out_value expected %0d actual %0d", r.value, v);
      failures++;
    end
    if (s !== r.src) begin
      $error("source_list expected %0d actual %0d", r.src, s);
      failures++;
    end
    if (d !== r.done) begin
      $error("all_done expected %0b actual %0b", r.done, d);
      failures++;
    end
    if (e !== r.err) begin
      $error("order_error expected %0b actual %0b", r.err, e);
      failures++;
    end
  endfunction
endclass

module tb_k_way_sorted_merge_top;
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [3:0]         cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               req_type = 1'b0;
  logic [2:0]         list_id = '0;
  logic signed [31:0] elem_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_value;
  logic [2:0]         source_list;
  logic               all_done;
  logic               order_error;

  merge_scoreboard sb;
  int              burst_left = 1;
  bit              sending = 1'b0;
  longint          last_val [8];
  int              remaining [8];

  k_way_sorted_merge_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .list_id(list_id),
    .elem_value(elem_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_value(out_value),
    .source_list(source_list),
    .all_done(all_done),
    .order_error(order_error)
  );

  always #5 clk = ~clk;

  task automatic send_item(input logic rt, input logic [2:0] lid,
                           input logic signed [31:0] val);
    in_valid <= 1'b1;
    req_type <= rt;
    list_id <= lid;
    elem_value <= val;
    sending = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(rt, lid, val);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      sending = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
  endtask

  task automatic wait_idle();
    if (sending) begin
      in_valid <= 1'b0;
      sending = 1'b0;
    end
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [3:0] v);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    sb.set_active(v);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_noise(input bit keep_list_wrong);
    logic [2:0] lid;
    lid = keep_list_wrong ? sb.awaited ^ 3'($urandom_range(1, 7)) : 3'($urandom);
    send_item(1'($urandom), lid, $urandom);
  endtask

  task automatic send_next_of(input logic [2:0] lid);
    int     r;
    longint nxt;
    logic signed [31:0] val;
    if (remaining[lid] == 0) begin
      send_item(1'b1, lid, $urandom);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        val = $urandom;
      end else begin
        nxt = last_val[lid] + ((r < 30) ? $urandom_range(0, 3) : $urandom_range(0, 1 << 22));
        if (nxt > 64'sd2147483647) nxt = 64'sd2147483647;
        val = nxt[31:0];
      end
      last_val[lid] = longint'(val);
      remaining[lid]--;
      send_item(1'b0, lid, val);
    end
  endtask

  initial begin : receiver
    logic [15:0] pat;
    int          k;
    pat = 16'hffff;
    k = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        sb.check(out_value, source_list, all_done, order_error);
      k++;
      if (k % 64 == 0)
        pat = ($urandom_range(0, 2) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
      out_ready <= pat[k % 16];
    end
  end

  initial begin : timeout
    #20_000_000;
    $display("** k_way_sorted_merge_top: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int n;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // priming with a narrowed and widened list count
    write_cfg(4'd0);
    send_item(1'b0, 3'd5, 32'sd123);
    send_item(1'b1, 3'd7, -32'sd1);
    write_cfg(4'd15);
    send_item(1'b0, 3'd0, 32'h8000_0000);
    send_item(1'b0, 3'd0, 32'sd42);
    write_cfg(4'd3);
    send_item(1'b0, 3'd1, 32'h7fff_ffff);
    write_cfg(4'd1);
    send_item(1'b0, 3'd2, 32'sd9);
    send_item(1'b1, 3'd0, 32'sd0);
    write_cfg(4'd8);
    send_item(1'b0, 3'd2, 32'sd5);
    send_item(1'b0, 3'd3, 32'sd5);
    send_item(1'b1, 3'd4, $urandom);
    send_item(1'b0, 3'd5, -32'sd7);
    send_item(1'b0, 3'd6, 32'sd5);
    send_item(1'b0, 3'd7, 32'sd5);

    for (int i = 0; i < 8; i++) begin
      last_val[i] = 5;
      remaining[i] = $urandom_range(240, 320);
    end
    last_val[0] = -64'sd2147483648;
    last_val[5] = -7;
    remaining[1] = 0;
    remaining[4] = 0;

    // merge session with wrong-list noise and occasional config writes
    n = 0;
    while (sb.phase != kwm_pkg::PH_DONE) begin
      if ($urandom_range(0, 99) < 10) send_noise(1'b1);
      else send_next_of(sb.awaited);
      n++;
      if (n % 300 == 0 && sb.phase != kwm_pkg::PH_DONE) write_cfg(4'($urandom_range(0, 15)));
    end

    // everything after done is rejected
    for (int i = 0; i < 6; i++) send_noise(1'b0);
    write_cfg(4'd15);
    for (int i = 0; i < 4; i++) send_noise(1'b0);

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.failures == 0 && sb.pending_results.size() == 0) begin
      $display("** k_way_sorted_merge_top: PASSED **");
    end else begin
      $display("** k_way_sorted_merge_top: FAILED **");
    end
    $finish;
  end
endmodule
